[hdl/sprite_quad_batch_setup_core_macros.svh]
// Assertion macros shared by the sprite quad batch setup blocks.
// Both macros expect clk and rst_n in scope.
`ifndef SPRITE_QUAD_BATCH_SETUP_CORE_MACROS_SVH
`define SPRITE_QUAD_BATCH_SETUP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SQB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SQB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SQB_ASSERT(name, prop, msg)
`define SQB_ASSERT_IMP(name, ante, cons, msg)
`endif
`endif

[hdl/sqb_pkg.sv]
`default_nettype none
package sqb_pkg;

    localparam int MAX_BATCH_QUADS = 16384;
    localparam int TEXTURE_SLOTS   = 16;
    localparam int SLOT_W          = 4;
    localparam int QCOUNT_W        = 15;
    localparam int SCOUNT_W        = 5;
    localparam logic [QCOUNT_W-1:0] QC_MAX = QCOUNT_W'(MAX_BATCH_QUADS);
    localparam logic [SCOUNT_W-1:0] SC_MAX = SCOUNT_W'(TEXTURE_SLOTS);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int FULL_TURN = 23040;
    localparam int QUARTER   = 5760;

    localparam int DIV_STEPS = 30;

    localparam logic CMD_DRAW    = 1'b0;
    localparam logic CMD_EOF     = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Multiplier sequence for one vertex.
    localparam logic [3:0] STEP_X    = 4'd0;
    localparam logic [3:0] STEP_Y    = 4'd1;
    localparam logic [3:0] STEP_CXL  = 4'd2;
    localparam logic [3:0] STEP_CXH  = 4'd3;
    localparam logic [3:0] STEP_NSYL = 4'd4;
    localparam logic [3:0] STEP_NSYH = 4'd5;
    localparam logic [3:0] STEP_SXL  = 4'd6;
    localparam logic [3:0] STEP_SXH  = 4'd7;
    localparam logic [3:0] STEP_CYL  = 4'd8;
    localparam logic [3:0] STEP_CYH  = 4'd9;

    typedef struct packed {
        logic               command;
        logic [15:0]        texture_id;
        logic [31:0]        texture_size;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] size_x;
        logic signed [23:0] size_y;
        logic signed [15:0] rotation;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [63:0]        source_rect;
        logic [31:0]        color;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vert_color;
        logic [3:0]         tex_slot;
        logic [15:0]        slot_texture;
        logic [14:0]        flush_quads;
        logic               last;
    } res_t;

    typedef struct packed {
        logic                flush;
        logic [QCOUNT_W-1:0] flush_quads;
        logic                draw;
        logic [SLOT_W-1:0]   slot;
        cmd_t                cmd;
    } job_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_FLUSH,
        BS_TRIG,
        BS_SINCOS,
        BS_DIVSET,
        BS_DIV,
        BS_MUL,
        BS_ACC,
        BS_EMIT
    } back_state_t;

    // Sine at whole degrees, Q1.14.
    function automatic logic [14:0] qsin_at(input logic [6:0] i);
        logic [14:0] v;
        case (i)
            7'd0: v = 15'd0;         7'd1: v = 15'd286;     7'd2: v = 15'd572;
            7'd3: v = 15'd857;       7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
            7'd6: v = 15'd1713;      7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
            7'd9: v = 15'd2563;      7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;     7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;     7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;     7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
            7'd21: v = 15'd5871;     7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;     7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;     7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;     7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;     7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;     7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
            7'd39: v = 15'd10311;    7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
            7'd42: v = 15'd10963;    7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
            7'd45: v = 15'd11585;    7'd46: v = 15'd11786;  7'd47: v = 15'd11982;
            7'd48: v = 15'd12176;    7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
            7'd51: v = 15'd12733;    7'd52: v = 15'd12911;  7'd53: v = 15'd13085;
            7'd54: v = 15'd13255;    7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
            7'd57: v = 15'd13741;    7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
            7'd60: v = 15'd14189;    7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
            7'd63: v = 15'd14598;    7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
            7'd66: v = 15'd14968;    7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
            7'd69: v = 15'd15296;    7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
            7'd72: v = 15'd15582;    7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
            7'd75: v = 15'd15826;    7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
            7'd78: v = 15'd16026;    7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
            7'd81: v = 15'd16182;    7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
            7'd84: v = 15'd16294;    7'd85: v = 15'd16321;  7'd86: v = 15'd16344;
            7'd87: v = 15'd16362;    7'd88: v = 15'd16374;  7'd89: v = 15'd16381;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // Sine over one quarter wave, x in 0..5760, interpolated in 64 steps.
    function automatic logic [14:0] quarter_sin(input logic [12:0] x);
        logic [6:0]  i;
        logic [5:0]  f;
        logic [14:0] base;
        logic [14:0] nxt;
        logic [8:0]  diff;
        logic [14:0] prod;
        i    = x[12:6];
        f    = x[5:0];
        base = qsin_at(i);
        nxt  = qsin_at(i + 7'd1);
        diff = 9'(nxt - base);
        prod = 15'(diff * f) + 15'd32;
        if (i >= 7'd90)
        begin
            return 15'd16384;
        end
        return base + 15'(prod[14:6]);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
        if (v > 44'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -44'sd8388608)
        begin
            return -24'sd8388608;
        end
        return $signed(v[23:0]);
    endfunction

endpackage
`default_nettype wire

[hdl/sqb_cmd_if.sv]
`default_nettype none
interface sqb_cmd_if;
    import sqb_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/sqb_res_if.sv]
`default_nettype none
interface sqb_res_if;
    import sqb_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/sprite_quad_batch_setup_core.sv]
// Sprite quad batch setup: each command item either draws one quad or ends the frame. A front
// stage resolves the texture slot and batch bookkeeping and queues the work; a back stage
// emits an optional batch flush result and then, for a draw, the four vertices of the quad. A
// draw first looks up the sine and cosine; with a source rectangle it then forms the four
// texture coordinates through one shared bit-serial divider; each vertex then goes through one
// shared 25 by 25 multiplier that forms ten products per vertex. The two-entry queue lets the
// front accept items while the back is busy.
`default_nettype none
module sprite_quad_batch_setup_core (
    input  logic     clk,
    input  logic     rst_n,
    sqb_cmd_if.sink  cmd,
    sqb_res_if.source res
);
    import sqb_pkg::*;

    job_t front_job;
    logic front_push;
    logic queue_full;
    job_t head_job;
    logic head_valid;
    logic head_pop;

    sqb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd.data),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .job       (front_job),
        .job_push  (front_push),
        .job_full  (queue_full)
    );

    sqb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_data   (front_job),
        .push      (front_push),
        .full      (queue_full),
        .rd_data   (head_job),
        .not_empty (head_valid),
        .pop       (head_pop)
    );

    sqb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (head_pop),
        .res_data  (res.data),
        .res_valid (res.valid),
        .res_ready (res.ready)
    );

endmodule
`default_nettype wire

[hdl/sqb_front.sv]
`default_nettype none
`include "sprite_quad_batch_setup_core_macros.svh"
module sqb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  sqb_pkg::cmd_t cmd_data,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output sqb_pkg::job_t job,
    output logic          job_push,
    input  logic          job_full
);
    import sqb_pkg::*;

    logic [QCOUNT_W-1:0] quad_count_reg, quad_count_next;
    logic [SCOUNT_W-1:0] slot_count_reg, slot_count_next;
    logic [15:0]         slot_ids_reg [TEXTURE_SLOTS];

    logic                accept;
    logic                pre_flush;
    logic [SCOUNT_W-1:0] sc_eff;
    logic [SCOUNT_W-1:0] sc_base;
    logic                found;
    logic [SLOT_W-1:0]   hit;
    logic                new_tex;
    logic                full_flush;
    logic                write_slot;

    assign cmd_ready = !job_full;
    assign accept    = cmd_valid && cmd_ready;

    assign pre_flush = quad_count_reg >= QC_MAX;
    assign sc_eff    = pre_flush ? SCOUNT_W'(1) : slot_count_reg;

    // Slot 0 always holds the default texture, so the search starts at 1.
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int i = 1; i < TEXTURE_SLOTS; i++)
        begin
            if (!found && (SCOUNT_W'(i) < sc_eff) && (slot_ids_reg[i] == cmd_data.texture_id))
            begin
                found = 1'b1;
                hit   = SLOT_W'(i);
            end
        end
    end

    assign new_tex    = (cmd_data.texture_id != 16'd0) && !found;
    assign full_flush = new_tex && (sc_eff >= SC_MAX);
    assign sc_base    = full_flush ? SCOUNT_W'(1) : sc_eff;

    always_comb
    begin
        job                 = '0;
        job.cmd             = cmd_data;
        job_push            = 1'b0;
        write_slot          = 1'b0;
        quad_count_next     = quad_count_reg;
        slot_count_next     = slot_count_reg;
        if (accept)
        begin
            if (cmd_data.command == CMD_EOF)
            begin
                job.flush       = quad_count_reg != '0;
                job.flush_quads = quad_count_reg;
                job_push        = quad_count_reg != '0;
                if (quad_count_reg != '0)
                begin
                    quad_count_next = '0;
                    slot_count_next = SCOUNT_W'(1);
                end
            end
            else
            begin
                // At most one of the two flush causes can find a non-empty batch.
                job.flush       = pre_flush || (full_flush && quad_count_reg != '0);
                job.flush_quads = quad_count_reg;
                job.draw        = 1'b1;
                job_push        = 1'b1;
                if (cmd_data.texture_id == 16'd0)
                begin
                    job.slot = '0;
                end
                else if (found)
                begin
                    job.slot = hit;
                end
                else
                begin
                    job.slot   = sc_base[SLOT_W-1:0];
                    write_slot = 1'b1;
                end
                slot_count_next = new_tex ? sc_base + SCOUNT_W'(1) : sc_eff;
                quad_count_next = ((pre_flush || full_flush) ? '0 : quad_count_reg)
                                  + QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_count_reg <= '0;
            slot_count_reg <= SCOUNT_W'(1);
        end
        else
        begin
            quad_count_reg <= quad_count_next;
            slot_count_reg <= slot_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_slot)
        begin
            slot_ids_reg[job.slot] <= cmd_data.texture_id;
        end
    end

    `SQB_ASSERT(a_quad_count_bound, quad_count_reg <= QC_MAX, "quad count above batch limit")
    `SQB_ASSERT(a_slot_count_bound, (slot_count_reg != '0) && (slot_count_reg <= SC_MAX), "slot count out of range")

endmodule
`default_nettype wire

[hdl/sqb_queue.sv]
`default_nettype none
`include "sprite_quad_batch_setup_core_macros.svh"
module sqb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  sqb_pkg::job_t wr_data,
    input  logic          push,
    output logic          full,
    output sqb_pkg::job_t rd_data,
    output logic          not_empty,
    input  logic          pop
);
    import sqb_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SQB_ASSERT_IMP(a_no_overflow, push, !full || pop, "item pushed into a full queue")

endmodule
`default_nettype wire

[hdl/sqb_back.sv]
`default_nettype none
`include "sprite_quad_batch_setup_core_macros.svh"
module sqb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sqb_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_pop,
    output sqb_pkg::res_t res_data,
    output logic          res_valid,
    input  logic          res_ready
);
    import sqb_pkg::*;

    back_state_t        state_reg, state_next;
    job_t               job_reg;
    res_t               out_reg;
    logic               out_valid_reg;
    logic [1:0]         quad_reg;
    logic [12:0]        r_reg;
    logic [12:0]        rc_reg;
    logic signed [15:0] s_reg;
    logic signed [15:0] c_reg;
    logic signed [15:0] ns_reg;
    logic [15:0]        uv_reg [4];
    logic [1:0]         cidx_reg;
    logic [29:0]        div_n_reg;
    logic [15:0]        div_rem_reg;
    logic [15:0]        div_d_reg;
    logic [4:0]         div_cnt_reg;
    logic [3:0]         step_reg;
    logic [1:0]         vert_reg;
    logic signed [49:0] prod_reg;
    logic signed [48:0] x_reg;
    logic signed [48:0] y_reg;
    logic signed [63:0] accx_reg;
    logic signed [63:0] accy_reg;

    logic               out_free;
    logic               out_load;
    logic               whole_tex;
    logic [16:0]        num;
    logic [15:0]        den;
    logic [16:0]        div_t;
    logic               div_ge;
    logic [29:0]        div_n_new;
    logic [15:0]        div_rem_new;
    logic [15:0]        div_q_sat;
    logic signed [16:0] rot_sat;
    logic signed [16:0] rot_wrap;
    logic [1:0]         quad_new;
    logic [14:0]        quad_base;
    logic [12:0]        r_new;
    logic [14:0]        qs_r;
    logic [14:0]        qs_rc;
    logic signed [15:0] s_new;
    logic signed [15:0] c_new;
    logic               cx_pos;
    logic               cy_pos;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [63:0] prod_lo;
    logic signed [63:0] prod_hi;
    logic signed [63:0] rnd_x;
    logic signed [63:0] rnd_y;
    logic signed [43:0] sum_x;
    logic signed [43:0] sum_y;
    res_t               vert_res;
    res_t               flush_res;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_data  = out_reg;
    assign res_valid = out_valid_reg;

    assign whole_tex = (job_reg.cmd.source_rect[47:32] == 16'd0)
                       || (job_reg.cmd.source_rect[63:48] == 16'd0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.flush ? BS_FLUSH : BS_TRIG;
                end
            end
            BS_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = job_reg.draw ? BS_TRIG : BS_IDLE;
                end
            end
            BS_TRIG:   state_next = BS_SINCOS;
            BS_SINCOS: state_next = whole_tex ? BS_MUL : BS_DIVSET;
            BS_DIVSET:
            begin
                if (den != 16'd0)
                begin
                    state_next = BS_DIV;
                end
                else if (cidx_reg == 2'd3)
                begin
                    state_next = BS_MUL;
                end
            end
            BS_DIV:
            begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = (cidx_reg == 2'd3) ? BS_MUL : BS_DIVSET;
                end
            end
            BS_MUL: state_next = BS_ACC;
            BS_ACC: state_next = (step_reg == STEP_CYH) ? BS_EMIT : BS_MUL;
            BS_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (vert_reg == 2'd3) ? BS_IDLE : BS_MUL;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        job_pop  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BS_IDLE:  job_pop  = job_valid;
            BS_FLUSH: out_load = out_free;
            BS_EMIT:  out_load = out_free;
            default:
            begin
                job_pop  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Texture coordinate operands.
    always_comb
    begin
        case (cidx_reg)
            2'd0:
            begin
                num = {1'b0, job_reg.cmd.source_rect[15:0]};
                den = job_reg.cmd.texture_size[15:0];
            end
            2'd1:
            begin
                num = {1'b0, job_reg.cmd.source_rect[15:0]} + {1'b0, job_reg.cmd.source_rect[47:32]};
                den = job_reg.cmd.texture_size[15:0];
            end
            2'd2:
            begin
                num = {1'b0, job_reg.cmd.source_rect[31:16]};
                den = job_reg.cmd.texture_size[31:16];
            end
            default:
            begin
                num = {1'b0, job_reg.cmd.source_rect[31:16]} + {1'b0, job_reg.cmd.source_rect[63:48]};
                den = job_reg.cmd.texture_size[31:16];
            end
        endcase
    end

    // One quotient bit per cycle.
    assign div_t       = {div_rem_reg, div_n_reg[29]};
    assign div_ge      = div_t >= {1'b0, div_d_reg};
    assign div_rem_new = div_ge ? 16'(div_t - {1'b0, div_d_reg}) : div_t[15:0];
    assign div_n_new   = {div_n_reg[28:0], div_ge};
    assign div_q_sat   = (div_n_new[29:16] != '0) ? 16'hFFFF : div_n_new[15:0];

    // Angle reduction to quadrant and remainder.
    always_comb
    begin
        rot_sat = 17'(job_reg.cmd.rotation);
        if (rot_sat > 17'sd23040)
        begin
            rot_sat = 17'sd23040;
        end
        if (rot_sat < -17'sd23040)
        begin
            rot_sat = -17'sd23040;
        end
        rot_wrap = rot_sat;
        if (rot_wrap < 17'sd0)
        begin
            rot_wrap = rot_wrap + 17'(FULL_TURN);
        end
        if (rot_wrap >= 17'(FULL_TURN))
        begin
            rot_wrap = rot_wrap - 17'(FULL_TURN);
        end
        if (rot_wrap >= 17'(3 * QUARTER))
        begin
            quad_new  = 2'd3;
            quad_base = 15'(3 * QUARTER);
        end
        else if (rot_wrap >= 17'(2 * QUARTER))
        begin
            quad_new  = 2'd2;
            quad_base = 15'(2 * QUARTER);
        end
        else if (rot_wrap >= 17'(QUARTER))
        begin
            quad_new  = 2'd1;
            quad_base = 15'(QUARTER);
        end
        else
        begin
            quad_new  = 2'd0;
            quad_base = 15'd0;
        end
        r_new = 13'(rot_wrap[14:0] - quad_base);
    end

    assign qs_r  = quarter_sin(r_reg);
    assign qs_rc = quarter_sin(rc_reg);

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                s_new = $signed({1'b0, qs_r});
                c_new = $signed({1'b0, qs_rc});
            end
            2'd1:
            begin
                s_new = $signed({1'b0, qs_rc});
                c_new = -$signed({1'b0, qs_r});
            end
            2'd2:
            begin
                s_new = -$signed({1'b0, qs_r});
                c_new = -$signed({1'b0, qs_rc});
            end
            default:
            begin
                s_new = -$signed({1'b0, qs_rc});
                c_new = $signed({1'b0, qs_r});
            end
        endcase
    end

    // Corner order: (-,-), (+,-), (+,+), (-,+).
    assign cx_pos = (vert_reg == 2'd1) || (vert_reg == 2'd2);
    assign cy_pos = vert_reg[1];
    assign dx = (cx_pos ? 25'sd128 : -25'sd128) - 25'(job_reg.cmd.origin_x);
    assign dy = (cy_pos ? 25'sd128 : -25'sd128) - 25'(job_reg.cmd.origin_y);

    always_comb
    begin
        case (step_reg)
            STEP_X:
            begin
                mul_a = 25'(job_reg.cmd.size_x);
                mul_b = dx;
            end
            STEP_Y:
            begin
                mul_a = 25'(job_reg.cmd.size_y);
                mul_b = dy;
            end
            STEP_CXL:
            begin
                mul_a = 25'(c_reg);
                mul_b = $signed({1'b0, x_reg[23:0]});
            end
            STEP_CXH:
            begin
                mul_a = 25'(c_reg);
                mul_b = x_reg[48:24];
            end
            STEP_NSYL:
            begin
                mul_a = 25'(ns_reg);
                mul_b = $signed({1'b0, y_reg[23:0]});
            end
            STEP_NSYH:
            begin
                mul_a = 25'(ns_reg);
                mul_b = y_reg[48:24];
            end
            STEP_SXL:
            begin
                mul_a = 25'(s_reg);
                mul_b = $signed({1'b0, x_reg[23:0]});
            end
            STEP_SXH:
            begin
                mul_a = 25'(s_reg);
                mul_b = x_reg[48:24];
            end
            STEP_CYL:
            begin
                mul_a = 25'(c_reg);
                mul_b = $signed({1'b0, y_reg[23:0]});
            end
            default:
            begin
                mul_a = 25'(c_reg);
                mul_b = y_reg[48:24];
            end
        endcase
    end

    assign prod_lo = 64'(prod_reg);
    assign prod_hi = {prod_lo[39:0], 24'd0};

    // Round to Q.8 with the half rounded up, then add origin and position.
    assign rnd_x = (accx_reg + 64'sd2097152) >>> 22;
    assign rnd_y = (accy_reg + 64'sd2097152) >>> 22;
    assign sum_x = rnd_x[43:0] + 44'(job_reg.cmd.origin_x) + 44'(job_reg.cmd.pos_x);
    assign sum_y = rnd_y[43:0] + 44'(job_reg.cmd.origin_y) + 44'(job_reg.cmd.pos_y);

    always_comb
    begin
        vert_res              = '0;
        vert_res.kind         = KIND_VERTEX;
        vert_res.vert_x       = sat24(sum_x);
        vert_res.vert_y       = sat24(sum_y);
        vert_res.tex_u        = cx_pos ? uv_reg[1] : uv_reg[0];
        vert_res.tex_v        = cy_pos ? uv_reg[3] : uv_reg[2];
        vert_res.vert_color   = job_reg.cmd.color;
        vert_res.tex_slot     = job_reg.slot;
        vert_res.slot_texture = job_reg.cmd.texture_id;
        vert_res.last         = vert_reg == 2'd3;
        flush_res             = '0;
        flush_res.kind        = KIND_FLUSH;
        flush_res.flush_quads = job_reg.flush_quads;
        flush_res.last        = !job_reg.draw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= (state_reg == BS_FLUSH) ? flush_res : vert_res;
        end
        case (state_reg)
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                end
            end
            BS_TRIG:
            begin
                quad_reg <= quad_new;
                r_reg    <= r_new;
                rc_reg   <= 13'(QUARTER) - r_new;
            end
            BS_SINCOS:
            begin
                s_reg     <= s_new;
                c_reg     <= c_new;
                ns_reg    <= -s_new;
                cidx_reg  <= 2'd0;
                step_reg  <= STEP_X;
                vert_reg  <= 2'd0;
                uv_reg[0] <= 16'd0;
                uv_reg[1] <= 16'd4096;
                uv_reg[2] <= 16'd0;
                uv_reg[3] <= 16'd4096;
            end
            BS_DIVSET:
            begin
                if (den == 16'd0)
                begin
                    uv_reg[cidx_reg] <= (num == 17'd0) ? 16'd0 : 16'hFFFF;
                    cidx_reg         <= cidx_reg + 2'd1;
                end
                else
                begin
                    div_n_reg   <= {1'b0, num, 12'd0} + {15'd0, den[15:1]};
                    div_rem_reg <= 16'd0;
                    div_d_reg   <= den;
                    div_cnt_reg <= 5'd0;
                end
            end
            BS_DIV:
            begin
                div_n_reg   <= div_n_new;
                div_rem_reg <= div_rem_new;
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    uv_reg[cidx_reg] <= div_q_sat;
                    cidx_reg         <= cidx_reg + 2'd1;
                end
            end
            BS_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            BS_ACC:
            begin
                step_reg <= step_reg + 4'd1;
                case (step_reg) inside
                    STEP_X:                      x_reg    <= prod_reg[48:0];
                    STEP_Y:                      y_reg    <= prod_reg[48:0];
                    STEP_CXL:                    accx_reg <= prod_lo;
                    STEP_NSYL:                   accx_reg <= accx_reg + prod_lo;
                    STEP_CXH, STEP_NSYH:         accx_reg <= accx_reg + prod_hi;
                    STEP_SXL:                    accy_reg <= prod_lo;
                    STEP_CYL:                    accy_reg <= accy_reg + prod_lo;
                    default:                     accy_reg <= accy_reg + prod_hi;
                endcase
            end
            BS_EMIT:
            begin
                if (out_free)
                begin
                    vert_reg <= vert_reg + 2'd1;
                    step_reg <= STEP_X;
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
    end

    `SQB_ASSERT_IMP(a_flush_nonzero, out_valid_reg && (out_reg.kind == KIND_FLUSH), out_reg.flush_quads != '0, "empty batch flushed")

endmodule
`default_nettype wire

[tb/sv/tb_sprite_quad_batch_setup_core.sv]
`timescale 1ns / 1ps
module tb_sprite_quad_batch_setup_core;
    import sqb_pkg::*;

    localparam int  RANDOM_ITEMS = 413;
    localparam int  HOLD_CYCLES  = 3000;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam int SINE_DEG [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5871, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16321, 16344, 16362, 16374, 16381,
        16384
    };

    logic clk;
    logic rst_n;

    sqb_cmd_if cmd_ch ();
    sqb_res_if res_ch ();

    sprite_quad_batch_setup_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // Batch state as the block should hold it.
    logic [15:0] bound_ids [16];
    int          bound_count;
    int          batch_quads;
    res_t        pending_results [$];

    cmd_t        script [$];
    bit          script_typed [$];
    int          script_quads [$];

    int          errors;
    int          items_taken;
    int          results_seen;
    int          flushes_seen;
    longint      cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("sprite_quad_batch_setup_core verification failed");
            $finish;
        end
    end

    function automatic longint quarter_wave(longint r);
        longint i;
        longint f;
        i = r >>> 6;
        f = r & 63;
        if (i >= 90)
        begin
            return 16384;
        end
        return SINE_DEG[i] + (((SINE_DEG[i + 1] - SINE_DEG[i]) * f + 32) >>> 6);
    endfunction

    function automatic logic [15:0] uv_coord(longint num, longint den);
        longint v;
        if (den == 0)
        begin
            return (num == 0) ? 16'd0 : 16'hFFFF;
        end
        v = ((num << 12) + den / 2) / den;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [23:0] clamp_q8(longint v);
        if (v > 8388607)
        begin
            return 24'h7FFFFF;
        end
        if (v < -8388608)
        begin
            return 24'h800000;
        end
        return 24'(v);
    endfunction

    function automatic res_t batch_flush_result(int quads, logic is_last);
        res_t r;
        r = '0;
        r.kind = KIND_FLUSH;
        r.flush_quads = 15'(quads);
        r.last = is_last;
        return r;
    endfunction

    // Works out the results of one accepted command and advances the batch state.
    task automatic predict_quad_results(cmd_t c, bit typed, int typed_quads);
        res_t   r;
        int     slot;
        bit     found;
        longint a, q, rm, sn, cs, sx, sy, ox, oy, cx, cy, bx, by, xr, yr;
        logic [15:0] tw, th, rx, ry, rw, rh, umin, umax, vmin, vmax;
        slot = 0;
        found = 0;
        if (c.command == CMD_EOF)
        begin
            if (typed)
            begin
                if (typed_quads != 0)
                begin
                    pending_results.push_back(batch_flush_result(typed_quads, 1'b1));
                end
            end
            else if (batch_quads != 0)
            begin
                pending_results.push_back(batch_flush_result(batch_quads, 1'b1));
            end
            if (batch_quads != 0)
            begin
                batch_quads = 0;
                bound_count = 1;
            end
            return;
        end
        if (batch_quads >= MAX_BATCH_QUADS)
        begin
            pending_results.push_back(batch_flush_result(batch_quads, 1'b0));
            batch_quads = 0;
            bound_count = 1;
        end
        if (c.texture_id != 16'd0)
        begin
            for (int i = 0; i < bound_count && i < 16; i++)
            begin
                if (!found && bound_ids[i] == c.texture_id)
                begin
                    slot = i;
                    found = 1;
                end
            end
            if (!found)
            begin
                if (bound_count >= TEXTURE_SLOTS)
                begin
                    if (batch_quads != 0)
                    begin
                        pending_results.push_back(batch_flush_result(batch_quads, 1'b0));
                        batch_quads = 0;
                    end
                    bound_count = 1;
                end
                slot = bound_count & 15;
                bound_ids[slot] = c.texture_id;
                bound_count = slot + 1;
            end
        end

        tw = c.texture_size[15:0];
        th = c.texture_size[31:16];
        rx = c.source_rect[15:0];
        ry = c.source_rect[31:16];
        rw = c.source_rect[47:32];
        rh = c.source_rect[63:48];
        if (rw != 0 && rh != 0)
        begin
            umin = uv_coord(rx, tw);
            umax = uv_coord(longint'(rx) + rw, tw);
            vmin = uv_coord(ry, th);
            vmax = uv_coord(longint'(ry) + rh, th);
        end
        else
        begin
            umin = 16'd0;
            vmin = 16'd0;
            umax = 16'd4096;
            vmax = 16'd4096;
        end

        a = c.rotation;
        if (a > FULL_TURN) a = FULL_TURN;
        if (a < -FULL_TURN) a = -FULL_TURN;
        if (a < 0) a += FULL_TURN;
        if (a >= FULL_TURN) a -= FULL_TURN;
        q = a / QUARTER;
        rm = a % QUARTER;
        case (q)
            0:
            begin
                sn = quarter_wave(rm);
                cs = quarter_wave(QUARTER - rm);
            end
            1:
            begin
                sn = quarter_wave(QUARTER - rm);
                cs = -quarter_wave(rm);
            end
            2:
            begin
                sn = -quarter_wave(rm);
                cs = -quarter_wave(QUARTER - rm);
            end
            default:
            begin
                sn = -quarter_wave(QUARTER - rm);
                cs = quarter_wave(rm);
            end
        endcase

        sx = c.size_x;
        sy = c.size_y;
        ox = c.origin_x;
        oy = c.origin_y;
        for (int k = 0; k < 4; k++)
        begin
            cx = (k == 1 || k == 2) ? 128 : -128;
            cy = (k >= 2) ? 128 : -128;
            bx = sx * (cx - ox);
            by = sy * (cy - oy);
            // Arithmetic shift gives the floor, so adding the half rounds it up.
            xr = (cs * bx - sn * by + (longint'(1) << 21)) >>> 22;
            yr = (sn * bx + cs * by + (longint'(1) << 21)) >>> 22;
            r = '0;
            r.kind = KIND_VERTEX;
            r.vert_x = clamp_q8(xr + ox + longint'(c.pos_x));
            r.vert_y = clamp_q8(yr + oy + longint'(c.pos_y));
            r.tex_u = (k == 1 || k == 2) ? umax : umin;
            r.tex_v = (k >= 2) ? vmax : vmin;
            r.vert_color = c.color;
            r.tex_slot = 4'(slot);
            r.slot_texture = bound_ids[slot];
            r.last = (k == 3);
            pending_results.push_back(r);
        end
        batch_quads++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Sampling at the edge sees the values from before the edge, so there is no race.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (items_taken < script.size())
                begin
                    predict_quad_results(cmd_ch.data, script_typed[items_taken],
                                         script_quads[items_taken]);
                end
                else
                begin
                    predict_quad_results(cmd_ch.data, 1'b0, 0);
                end
                items_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                results_seen++;
                if (got.kind == KIND_FLUSH)
                begin
                    flushes_seen++;
                end
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected item: expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("vert_x", want.vert_x, got.vert_x);
                    check_field("vert_y", want.vert_y, got.vert_y);
                    check_field("tex_u", want.tex_u, got.tex_u);
                    check_field("tex_v", want.tex_v, got.tex_v);
                    check_field("vert_color", want.vert_color, got.vert_color);
                    check_field("tex_slot", want.tex_slot, got.tex_slot);
                    check_field("slot_texture", want.slot_texture, got.slot_texture);
                    check_field("flush_quads", want.flush_quads, got.flush_quads);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    function automatic cmd_t plain_draw();
        cmd_t c;
        c = '0;
        c.command = CMD_DRAW;
        c.texture_size = {16'd64, 16'd64};
        c.pos_x = 24'sd25600;
        c.pos_y = 24'sd12800;
        c.size_x = 24'sd4096;
        c.size_y = 24'sd2048;
        c.color = 32'h80FF4020;
        return c;
    endfunction

    task automatic add_row(cmd_t c, bit typed, int quads);
        script.push_back(c);
        script_typed.push_back(typed);
        script_quads.push_back(quads);
    endtask

    task automatic build_directed();
        cmd_t c;
        c = '0;
        c.command = CMD_EOF;
        // End of frame straight after reset finds an empty batch.
        add_row(c, 1, 0);
        c = plain_draw();
        add_row(c, 0, 0);
        c.rotation = 16'sd23040;
        add_row(c, 0, 0);
        c.rotation = -16'sd23040;
        add_row(c, 0, 0);
        c.rotation = 16'sd5760;
        add_row(c, 0, 0);
        c.rotation = 16'sh7FFF;
        add_row(c, 0, 0);
        c.rotation = 16'sh8000;
        add_row(c, 0, 0);
        c = plain_draw();
        c.pos_x = 24'sh7FFFFF;
        c.pos_y = 24'sh7FFFFF;
        c.size_x = 24'sh7FFFFF;
        c.size_y = 24'sh7FFFFF;
        add_row(c, 0, 0);
        c.pos_x = 24'sh800000;
        c.pos_y = 24'sh800000;
        c.size_x = 24'sh800000;
        c.size_y = 24'sh800000;
        c.origin_x = 24'sh7FFFFF;
        c.origin_y = 24'sh7FFFFF;
        c.rotation = 16'sd7000;
        add_row(c, 0, 0);
        c.origin_x = 24'sh800000;
        c.origin_y = 24'sh800000;
        add_row(c, 0, 0);
        // Zero texture dimensions: a zero numerator gives 0, anything else saturates.
        c = plain_draw();
        c.texture_id = 16'd1;
        c.texture_size = '0;
        c.source_rect = {16'd8, 16'd8, 16'd0, 16'd4};
        add_row(c, 0, 0);
        c.texture_id = 16'hFFFF;
        c.texture_size = 32'hFFFFFFFF;
        c.source_rect = 64'hFFFFFFFFFFFFFFFF;
        add_row(c, 0, 0);
        c.source_rect = {16'd9, 16'd0, 16'd3, 16'd2};
        add_row(c, 0, 0);
        c = plain_draw();
        c.texture_id = 16'd1;
        c.color = 32'hFFFFFFFF;
        add_row(c, 0, 0);
        c = '0;
        c.command = CMD_EOF;
        add_row(c, 1, 13);
        add_row(c, 1, 0);
        c = plain_draw();
        c.rotation = -16'sd1;
        c.texture_size = {16'd100, 16'd200};
        c.source_rect = {16'd50, 16'd40, 16'd30, 16'd20};
        add_row(c, 0, 0);
    endtask

    function automatic logic [23:0] rand_q8();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 8192) - 4096);
            default: return 24'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        c = '0;
        c.command = ($urandom_range(0, 99) < 8) ? CMD_EOF : CMD_DRAW;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            c.texture_id = 16'd0;
        else if (pick < 8)
            c.texture_id = 16'($urandom_range(1, 24));
        else
            c.texture_id = 16'($urandom);
        c.texture_size = $urandom;
        if ($urandom_range(0, 9) == 0)
            c.texture_size[15:0] = '0;
        if ($urandom_range(0, 9) == 0)
            c.texture_size[31:16] = '0;
        c.pos_x = rand_q8();
        c.pos_y = rand_q8();
        c.size_x = rand_q8();
        c.size_y = rand_q8();
        c.origin_x = rand_q8();
        c.origin_y = rand_q8();
        if ($urandom_range(0, 7) == 0)
            c.rotation = 16'($urandom);
        else
            c.rotation = 16'($urandom_range(0, 46080) - 23040);
        case ($urandom_range(0, 3))
            0: c.source_rect = {$urandom, $urandom};
            1: c.source_rect = {$urandom, $urandom} & 64'h0000FFFF_FFFFFFFF;
            default: c.source_rect = {16'($urandom_range(1, 256)), 16'($urandom_range(1, 256)),
                                      16'($urandom_range(0, 512)), 16'($urandom_range(0, 512))};
        endcase
        c.color = $urandom;
        return c;
    endfunction

    // Sender: bursts of items with random gaps; valid stays high across a burst.
    task automatic send_all();
        int burst;
        int total;
        int gap;
        cmd_t c;
        total = script.size() + RANDOM_ITEMS;
        burst = 0;
        for (int n = 0; n < total; n++)
        begin
            c = (n < script.size()) ? script[n] : random_command();
            cmd_ch.valid <= 1'b1;
            cmd_ch.data <= c;
            do
                @(posedge clk);
            while (!cmd_ch.ready);
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                // With no gap the next item follows at once, so valid is not dropped.
                if (gap != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
            else
            begin
                burst--;
            end
        end
        cmd_ch.valid <= 1'b0;
    endtask

    // Receiver: changes its stall pattern every so often, and once holds off for a long stretch.
    initial
    begin
        int  mode;
        bit  held;
        held = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 64; i++)
            begin
                @(posedge clk);
                if (!held && items_taken > 150)
                begin
                    held = 1;
                    res_ch.ready <= 1'b0;
                    for (int h = 0; h < HOLD_CYCLES; h++)
                        @(posedge clk);
                end
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin
        errors = 0;
        items_taken = 0;
        results_seen = 0;
        flushes_seen = 0;
        cycles = 0;
        batch_quads = 0;
        bound_count = 1;
        for (int i = 0; i < 16; i++)
            bound_ids[i] = '0;
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data <= '0;
        build_directed();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_all();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Covered %0d commands (%0d directed), %0d results checked, %0d batch flushes.",
                 items_taken, script.size(), results_seen, flushes_seen);
        $display("Included saturating vertices, zero texture sizes, full slot tables %s",
                 "and a long output stall.");
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("sprite_quad_batch_setup_core verification clean");
        end
        else
        begin
            $display("sprite_quad_batch_setup_core verification failed");
        end
        $finish;
    end

endmodule
